// ===== src/jptc_pkg.sv =====
// jptc_pkg: widths, command codes and shared types for the joint torque controller
// no dependencies; used by the controller core and its multiply-accumulate unit
`timescale 1ns / 1ps

package jptc_pkg;

   // field and datapath widths
   localparam int DATA_W   = 32;
   localparam int ERR_W    = 33;
   localparam int PROD_W   = 66;
   localparam int ACC_W    = 52;
   localparam int DT_W     = 24;
   localparam int JOINT_W  = 3;
   localparam int ACTIVE_W = 4;
   localparam int FRAC_W   = 16;
   localparam int TIME_W   = 24;

   // command modes
   localparam logic [1:0] MODE_STEP  = 2'd0;
   localparam logic [1:0] MODE_GAIN  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   // gain selects for a gain write
   localparam logic [2:0] SEL_KP   = 3'd0;
   localparam logic [2:0] SEL_KV   = 3'd1;
   localparam logic [2:0] SEL_KI   = 3'd2;
   localparam logic [2:0] SEL_ILIM = 3'd3;
   localparam logic [2:0] SEL_OLIM = 3'd4;

   // product scaling applied by the accumulator
   localparam logic [1:0] SH_NONE = 2'd0;
   localparam logic [1:0] SH_FRAC = 2'd1;
   localparam logic [1:0] SH_TIME = 2'd2;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

   // 32-bit signed range in accumulator width
   localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

   // control word from the sequencer to the multiply-accumulate unit
   typedef struct packed {
      logic       mul_en;
      logic       acc_en;
      logic       acc_keep;
      logic [1:0] shift_sel;
   } mac_ctrl_type;

endpackage

// ===== src/joint_pid_torque_controller_core.sv =====
// joint_pid_torque_controller_core: per-joint pid torque controller, gain tables,
// integrators and the sequencer around one shared multiply-accumulate unit (jptc_mac).
// Gain writes, clears and rejected joints are answered by a registered strobe from idle; a
// step runs ST_KI_MUL, the integration states if ki and dt are nonzero, ST_KP_ADD, ST_KV_ADD
// and ST_OUT. New items are taken only while idle; the single multiplier serialises products.
// Synchronous active-high reset clears gains, integrators and control; active_joints = 8.
`timescale 1ns / 1ps

module joint_pid_torque_controller_core #(
   parameter int MAX_JOINTS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // command channel
   input  logic                                   start,
   output logic                                   busy,
   input  logic [1:0]                             req_mode,
   input  logic [jptc_pkg::JOINT_W-1:0]           req_joint_index,
   input  logic [2:0]                             req_gain_select,
   input  logic signed [jptc_pkg::DATA_W-1:0]     req_gain_value,
   input  logic [2:0]                             req_ref_flags,
   input  logic signed [jptc_pkg::DATA_W-1:0]     req_position_ref,
   input  logic signed [jptc_pkg::DATA_W-1:0]     req_velocity_ref,
   input  logic signed [jptc_pkg::DATA_W-1:0]     req_torque_feedforward,
   input  logic signed [jptc_pkg::DATA_W-1:0]     req_position_meas,
   input  logic signed [jptc_pkg::DATA_W-1:0]     req_velocity_meas,
   input  logic [jptc_pkg::DT_W-1:0]              req_time_step,
   // result channel
   output logic                                   rsp_strobe,
   output logic signed [jptc_pkg::DATA_W-1:0]     rsp_torque_out,
   output logic                                   rsp_status,
   output logic [jptc_pkg::JOINT_W-1:0]           rsp_joint_echo,
   // configuration
   input  logic                                   csr_wr_en,
   input  logic [jptc_pkg::ACTIVE_W-1:0]          csr_wr_data
);

   localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

   // sequencer states
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_KI_MUL = 4'd1;
   localparam logic [3:0] ST_T_LOAD = 4'd2;
   localparam logic [3:0] ST_A_MUL  = 4'd3;
   localparam logic [3:0] ST_A_ADD  = 4'd4;
   localparam logic [3:0] ST_B_ADD  = 4'd5;
   localparam logic [3:0] ST_INT_WR = 4'd6;
   localparam logic [3:0] ST_KP_ADD = 4'd7;
   localparam logic [3:0] ST_KV_ADD = 4'd8;
   localparam logic [3:0] ST_OUT    = 4'd9;

   // gain tables and integrators
   logic signed [jptc_pkg::DATA_W-1:0] kp_ff   [MAX_JOINTS];
   logic signed [jptc_pkg::DATA_W-1:0] kv_ff   [MAX_JOINTS];
   logic signed [jptc_pkg::DATA_W-1:0] ki_ff   [MAX_JOINTS];
   logic signed [jptc_pkg::DATA_W-1:0] ilim_ff [MAX_JOINTS];
   logic signed [jptc_pkg::DATA_W-1:0] olim_ff [MAX_JOINTS];
   logic signed [jptc_pkg::DATA_W-1:0] integ_ff[MAX_JOINTS];

   logic [3:0]                          state_ff, state_in;
   logic [jptc_pkg::ACTIVE_W-1:0]       active_ff;
   logic [JW-1:0]                       jidx_ff, jidx_in;
   logic signed [jptc_pkg::ERR_W-1:0]   err_ff, err_in;
   logic signed [jptc_pkg::ERR_W-1:0]   derr_ff, derr_in;
   logic signed [jptc_pkg::DATA_W-1:0]  ffwd_ff, ffwd_in;
   logic [jptc_pkg::DT_W-1:0]           dt_ff, dt_in;
   logic [jptc_pkg::TIME_W-1:0]         frac_ff, frac_in;
   logic [jptc_pkg::JOINT_W-1:0]        echo_ff, echo_in;
   logic                                strobe_ff, strobe_in;
   logic signed [jptc_pkg::DATA_W-1:0]  torque_ff, torque_in;
   logic                                status_ff, status_in;

   logic                                accept;
   logic                                joint_ok;
   logic                                gain_wr;
   logic                                int_wr;
   logic                                int_clear;
   logic signed [jptc_pkg::DATA_W-1:0]  pos_sel;
   logic signed [jptc_pkg::DATA_W-1:0]  vel_sel;
   logic signed [jptc_pkg::DATA_W-1:0]  int_next;
   logic signed [jptc_pkg::DATA_W-1:0]  int_sat;
   logic signed [jptc_pkg::DATA_W-1:0]  ilim_cur;
   logic signed [jptc_pkg::DATA_W-1:0]  olim_cur;
   logic signed [jptc_pkg::DATA_W-1:0]  torque_clamped;

   jptc_pkg::mac_ctrl_type              mac_ctrl;
   logic signed [jptc_pkg::ERR_W-1:0]   mac_a;
   logic signed [jptc_pkg::ERR_W-1:0]   mac_b;
   logic signed [jptc_pkg::ACC_W-1:0]   mac_addend;
   logic signed [jptc_pkg::ACC_W-1:0]   mac_acc;

   // saturate an accumulator value to the 32-bit signed range
   function automatic logic signed [jptc_pkg::DATA_W-1:0] sat32(
      input logic signed [jptc_pkg::ACC_W-1:0] v
   );
      priority if (v > jptc_pkg::SAT_HI) begin
         return jptc_pkg::SAT_HI[jptc_pkg::DATA_W-1:0];
      end else if (v < jptc_pkg::SAT_LO) begin
         return jptc_pkg::SAT_LO[jptc_pkg::DATA_W-1:0];
      end else begin
         return v[jptc_pkg::DATA_W-1:0];
      end
   endfunction

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // joint must be below both the active count and the table depth
   assign joint_ok = (jptc_pkg::ACTIVE_W'(req_joint_index) < active_ff) &&
                     (int'(req_joint_index) < MAX_JOINTS);

   // reference defaults
   assign pos_sel = req_ref_flags[0] ? req_position_ref : req_position_meas;
   assign vel_sel = req_ref_flags[1] ? req_velocity_ref : '0;

   assign ilim_cur = ilim_ff[jidx_ff];
   assign olim_cur = olim_ff[jidx_ff];

   // integrator saturation and optional clamp
   always_comb begin
      int_sat = sat32(mac_acc);
      int_next = int_sat;
      if (ilim_cur > 0) begin
         priority if (int_sat > ilim_cur) begin
            int_next = ilim_cur;
         end else if (int_sat < -ilim_cur) begin
            int_next = -ilim_cur;
         end else begin
            int_next = int_sat;
         end
      end
   end

   // output clamp by the joint limit, otherwise saturation
   always_comb begin
      torque_clamped = sat32(mac_acc);
      if (olim_cur > 0) begin
         priority if (mac_acc > jptc_pkg::ACC_W'(olim_cur)) begin
            torque_clamped = olim_cur;
         end else if (mac_acc < -jptc_pkg::ACC_W'(olim_cur)) begin
            torque_clamped = -olim_cur;
         end else begin
            torque_clamped = mac_acc[jptc_pkg::DATA_W-1:0];
         end
      end
   end

   // sequencer and shared unit control
   always_comb begin
      state_in   = state_ff;
      jidx_in    = jidx_ff;
      err_in     = err_ff;
      derr_in    = derr_ff;
      ffwd_in    = ffwd_ff;
      dt_in      = dt_ff;
      frac_in    = frac_ff;
      echo_in    = echo_ff;
      strobe_in  = 1'b0;
      torque_in  = torque_ff;
      status_in  = status_ff;
      gain_wr    = 1'b0;
      int_wr     = 1'b0;
      int_clear  = 1'b0;
      mac_ctrl   = '0;
      mac_a      = '0;
      mac_b      = '0;
      mac_addend = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               echo_in   = req_joint_index;
               torque_in = '0;
               status_in = 1'b0;
               jidx_in   = JW'(req_joint_index);
               err_in    = jptc_pkg::ERR_W'(pos_sel) - jptc_pkg::ERR_W'(req_position_meas);
               derr_in   = jptc_pkg::ERR_W'(vel_sel) - jptc_pkg::ERR_W'(req_velocity_meas);
               ffwd_in   = req_ref_flags[2] ? req_torque_feedforward : '0;
               dt_in     = req_time_step;
               unique case (req_mode)
                  jptc_pkg::MODE_STEP: begin
                     if (joint_ok) begin
                        state_in = ST_KI_MUL;
                     end else begin
                        status_in = 1'b1;
                        strobe_in = 1'b1;
                     end
                  end
                  jptc_pkg::MODE_GAIN: begin
                     gain_wr   = joint_ok;
                     status_in = !joint_ok;
                     strobe_in = 1'b1;
                  end
                  jptc_pkg::MODE_CLEAR: begin
                     int_clear = 1'b1;
                     strobe_in = 1'b1;
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_KI_MUL: begin
            mac_ctrl.mul_en = 1'b1;
            mac_b           = err_ff;
            if ((ki_ff[jidx_ff] != 0) && (dt_ff != '0)) begin
               mac_a    = jptc_pkg::ERR_W'(ki_ff[jidx_ff]);
               state_in = ST_T_LOAD;
            end else begin
               mac_a    = jptc_pkg::ERR_W'(kp_ff[jidx_ff]);
               state_in = ST_KP_ADD;
            end
         end
         ST_T_LOAD: begin
            // t = floor(ki * err / 2^16) held in the accumulator
            mac_ctrl.acc_en    = 1'b1;
            mac_ctrl.shift_sel = jptc_pkg::SH_FRAC;
            state_in           = ST_A_MUL;
         end
         ST_A_MUL: begin
            // whole-second part of t times dt; keep the fractional part
            frac_in         = mac_acc[jptc_pkg::TIME_W-1:0];
            mac_ctrl.mul_en = 1'b1;
            mac_a = jptc_pkg::ERR_W'($signed(mac_acc[jptc_pkg::ACC_W-1:jptc_pkg::TIME_W]));
            mac_b = jptc_pkg::ERR_W'(dt_ff);
            state_in        = ST_A_ADD;
         end
         ST_A_ADD: begin
            mac_ctrl.acc_en = 1'b1;
            mac_ctrl.mul_en = 1'b1;
            mac_addend      = jptc_pkg::ACC_W'(integ_ff[jidx_ff]);
            mac_a           = jptc_pkg::ERR_W'(frac_ff);
            mac_b           = jptc_pkg::ERR_W'(dt_ff);
            state_in        = ST_B_ADD;
         end
         ST_B_ADD: begin
            mac_ctrl.acc_en    = 1'b1;
            mac_ctrl.acc_keep  = 1'b1;
            mac_ctrl.shift_sel = jptc_pkg::SH_TIME;
            mac_ctrl.mul_en    = 1'b1;
            mac_a              = jptc_pkg::ERR_W'(kp_ff[jidx_ff]);
            mac_b              = err_ff;
            state_in           = ST_INT_WR;
         end
         ST_INT_WR: begin
            int_wr   = 1'b1;
            state_in = ST_KP_ADD;
         end
         ST_KP_ADD: begin
            mac_ctrl.acc_en    = 1'b1;
            mac_ctrl.shift_sel = jptc_pkg::SH_FRAC;
            mac_addend         = jptc_pkg::ACC_W'(integ_ff[jidx_ff]) +
                                 jptc_pkg::ACC_W'(ffwd_ff);
            mac_ctrl.mul_en    = 1'b1;
            mac_a              = jptc_pkg::ERR_W'(kv_ff[jidx_ff]);
            mac_b              = derr_ff;
            state_in           = ST_KV_ADD;
         end
         ST_KV_ADD: begin
            mac_ctrl.acc_en    = 1'b1;
            mac_ctrl.acc_keep  = 1'b1;
            mac_ctrl.shift_sel = jptc_pkg::SH_FRAC;
            state_in           = ST_OUT;
         end
         ST_OUT: begin
            torque_in = torque_clamped;
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   jptc_mac u_mac (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .op_a   (mac_a),
      .op_b   (mac_b),
      .addend (mac_addend),
      .acc    (mac_acc)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
         active_ff <= jptc_pkg::ACTIVE_RESET;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         if (csr_wr_en) begin
            active_ff <= csr_wr_data;
         end
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      jidx_ff   <= jidx_in;
      err_ff    <= err_in;
      derr_ff   <= derr_in;
      ffwd_ff   <= ffwd_in;
      dt_ff     <= dt_in;
      frac_ff   <= frac_in;
      echo_ff   <= echo_in;
      torque_ff <= torque_in;
      status_ff <= status_in;
   end

   // gain tables
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_JOINTS; i++) begin
            kp_ff[i]   <= '0;
            kv_ff[i]   <= '0;
            ki_ff[i]   <= '0;
            ilim_ff[i] <= '0;
            olim_ff[i] <= '0;
         end
      end else if (gain_wr) begin
         unique case (req_gain_select)
            jptc_pkg::SEL_KP:   kp_ff[jidx_in]   <= req_gain_value;
            jptc_pkg::SEL_KV:   kv_ff[jidx_in]   <= req_gain_value;
            jptc_pkg::SEL_KI:   ki_ff[jidx_in]   <= req_gain_value;
            jptc_pkg::SEL_ILIM: ilim_ff[jidx_in] <= req_gain_value;
            jptc_pkg::SEL_OLIM: olim_ff[jidx_in] <= req_gain_value;
            default: ;
         endcase
      end
   end

   // integrators
   always_ff @(posedge clock) begin
      if (reset || int_clear) begin
         for (int i = 0; i < MAX_JOINTS; i++) begin
            integ_ff[i] <= '0;
         end
      end else if (int_wr) begin
         integ_ff[jidx_ff] <= int_next;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_torque_out = torque_ff;
   assign rsp_status     = status_ff;
   assign rsp_joint_echo = echo_ff;

endmodule

// ===== src/jptc_mac.sv =====
// jptc_mac: shared signed 33x33 multiplier with a registered product and a
// 52-bit accumulator; depends on jptc_pkg
`timescale 1ns / 1ps

module jptc_mac (
   input  logic                                clock,
   input  jptc_pkg::mac_ctrl_type              ctrl,
   input  logic signed [jptc_pkg::ERR_W-1:0]   op_a,
   input  logic signed [jptc_pkg::ERR_W-1:0]   op_b,
   input  logic signed [jptc_pkg::ACC_W-1:0]   addend,
   output logic signed [jptc_pkg::ACC_W-1:0]   acc
);

   logic signed [jptc_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [jptc_pkg::PROD_W-1:0] prod_shr;
   logic signed [jptc_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic signed [jptc_pkg::ACC_W-1:0]  base;

   // one multiply per cycle, registered before use
   assign prod_in = op_a * op_b;

   // floor scaling of the stored product
   always_comb begin
      unique case (ctrl.shift_sel)
         jptc_pkg::SH_NONE: prod_shr = prod_ff;
         jptc_pkg::SH_FRAC: prod_shr = prod_ff >>> jptc_pkg::FRAC_W;
         jptc_pkg::SH_TIME: prod_shr = prod_ff >>> jptc_pkg::TIME_W;
         default:           prod_shr = prod_ff;
      endcase
   end

   // load or accumulate
   assign base   = ctrl.acc_keep ? acc_ff : addend;
   assign acc_in = base + prod_shr[jptc_pkg::ACC_W-1:0];

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctrl.acc_en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

// ===== src/jptc_checker.sv =====
// jptc_checker: port-level assertions for the joint torque controller core,
// bound onto joint_pid_torque_controller_core; depends on jptc_pkg
`timescale 1ns / 1ps

module jptc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic [1:0]                           req_mode,
   input logic [jptc_pkg::JOINT_W-1:0]         req_joint_index,
   input logic                                 rsp_strobe,
   input logic signed [jptc_pkg::DATA_W-1:0]   rsp_torque_out,
   input logic                                 rsp_status,
   input logic [jptc_pkg::JOINT_W-1:0]         rsp_joint_echo
);

   // a non-step item answers in the next cycle with zero torque and its joint
   a_nonstep_answer: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_mode != jptc_pkg::MODE_STEP)
      |=> rsp_strobe && (rsp_torque_out == 0) &&
          (rsp_joint_echo == $past(req_joint_index)))
      else $error("non-step item not answered at once");

   // a result is never shown while a step is still in progress
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // an error result carries zero torque
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status |-> (rsp_torque_out == 0))
      else $error("error result with nonzero torque");

   // a step that starts work gives no immediate result
   a_step_no_early: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> !rsp_strobe)
      else $error("result strobe as a step starts");

endmodule

bind joint_pid_torque_controller_core jptc_checker u_jptc_checker (.*);
